// File: hw/rtl/bcgi_pkg.sv
package bcgi_pkg;

    localparam int DEF_MAX_COLS    = 256;
    localparam int DEF_MAX_ROWS    = 256;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int WGT_W      = 18;
    localparam int POS_W      = 13;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Y = 3'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic signed [WGT_W-1:0] WGT_ONE = 18'sd65536;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         cell_col;
        logic [7:0]         cell_row;
        logic signed [15:0] cell_value;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
    } in_item_t;

    typedef struct packed {
        logic               value_valid;
        logic signed [23:0] value;
        logic               used_bicubic;
        logic               saturated;
    } out_item_t;

    typedef enum logic [1:0] {
        K_WRITE,
        K_MISS,
        K_QUERY
    } kind_t;

    typedef logic signed [WGT_W-1:0] wgt_t;
    typedef wgt_t [3:0] wgt4_t;

    typedef struct packed {
        kind_t              kind;
        logic               bicubic;
        logic [POS_W-1:0]   col_base;
        logic [POS_W-1:0]   row_base;
        wgt4_t              wx;
        wgt4_t              wy;
        logic               wr_en;
        logic [7:0]         wr_col;
        logic [7:0]         wr_row;
        logic signed [15:0] wr_value;
    } entry_t;

    // Catmull-Rom weights in Q1.16, rounded half up from the exact Q.49 sums
    function automatic wgt4_t cr_weights(input logic [15:0] t, input logic [31:0] t2,
                                         input logic [47:0] t3);
        logic signed [53:0] a1;
        logic signed [53:0] a2;
        logic signed [53:0] a3;
        logic signed [53:0] half;
        logic signed [53:0] s0;
        logic signed [53:0] s1;
        logic signed [53:0] s2;
        logic signed [53:0] s3;
        wgt4_t w;
        a1   = $signed({38'd0, t});
        a2   = $signed({22'd0, t2});
        a3   = $signed({6'd0, t3});
        half = 54'sd1 <<< 32;
        s0 = -a3 + (a2 <<< 17) - (a1 <<< 32) + half;
        s1 = 54'sd3 * a3 - 54'sd5 * (a2 <<< 16) + (54'sd1 <<< 49) + half;
        s2 = -(54'sd3 * a3) + (a2 <<< 18) + (a1 <<< 32) + half;
        s3 = a3 - (a2 <<< 16) + half;
        w[0] = s0[50:33];
        w[1] = s1[50:33];
        w[2] = s2[50:33];
        w[3] = s3[50:33];
        return w;
    endfunction

endpackage

// File: hw/rtl/bicubic_grid_interpolator.sv
// Bicubic grid interpolator.
// Input channel s_*: an item either writes one sample into the raster
// (cmd = write) or asks for the value at a world point (cmd = query).
// Result channel m_*: exactly one result per input item, in order. Writes and
// points off the grid return all-zero fields; interior points use a 4x4
// Catmull-Rom neighbourhood, points within one cell of the edge use bilinear.
// Configuration: cfg_we/cfg_index/cfg_data write the size, origin and
// reciprocal-step registers; write them only while idle.
// Pipeline: 4 front stages, then the back end. A query occupies the back end
// through the four column reads from the four row banks plus row rounding,
// vertical multiply and output; writes and misses are answered from its idle
// state. The back end takes no new item until a query is done.
// The front keeps accepting until the 2-entry queue and its pipeline fill.
// Reset clears control state and restores register defaults; raster contents
// are undefined until written. A stalled receiver holds the result register,
// which backs up the queue and then s_ready.
module bicubic_grid_interpolator #(
    parameter int MAX_COLS    = bcgi_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS    = bcgi_pkg::DEF_MAX_ROWS,
    parameter int SAMPLE_BITS = bcgi_pkg::DEF_SAMPLE_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [bcgi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bcgi_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bcgi_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output bcgi_pkg::out_item_t            m_data
);

    logic             fq_valid, fq_ready, qb_valid, qb_ready;
    bcgi_pkg::entry_t fq_data, qb_data;

    bcgi_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    bcgi_queue #(
        .DEPTH (bcgi_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    bcgi_back #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_ready (qb_ready),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: hw/rtl/bcgi_ram.sv
module bcgi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/bcgi_queue.sv
module bcgi_queue #(
    parameter int DEPTH = bcgi_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  bcgi_pkg::entry_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output bcgi_pkg::entry_t out_data
);

    localparam int PW = $clog2(DEPTH);

    bcgi_pkg::entry_t     slot_reg [DEPTH];
    logic [PW-1:0]        head_reg;
    logic [PW-1:0]        tail_reg;
    logic [PW:0]          count_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != (PW+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[head_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                slot_reg[tail_reg] <= in_data;
                tail_reg <= (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            end
            if (pop) begin
                head_reg <= (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/bcgi_front.sv
module bcgi_front #(
    parameter int MAX_COLS = bcgi_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = bcgi_pkg::DEF_MAX_ROWS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [bcgi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bcgi_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bcgi_pkg::in_item_t             s_data,
    output logic                           q_valid,
    input  logic                           q_ready,
    output bcgi_pkg::entry_t               q_data
);

    localparam int PW = bcgi_pkg::POS_W;

    logic [8:0]         grid_cols_reg;
    logic [8:0]         grid_rows_reg;
    logic signed [31:0] origin_x_reg;
    logic signed [31:0] origin_y_reg;
    logic signed [31:0] inv_x_reg;
    logic signed [31:0] inv_y_reg;

    // stage 1: offsets, stage 2: grid coordinates, stage 3: classify and t^2,
    // stage 4: t^3
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    bcgi_pkg::in_item_t p1_reg, p2_reg;
    logic signed [32:0] dx1_reg, dy1_reg;
    logic signed [48:0] gx2_reg, gy2_reg;
    bcgi_pkg::entry_t   e3_reg, e4_reg;
    logic [15:0]        tx3_reg, ty3_reg, tx4_reg, ty4_reg;
    logic [31:0]        tx2_3_reg, ty2_3_reg, tx2_4_reg, ty2_4_reg;
    logic [47:0]        tx3_4_reg, ty3_4_reg;

    logic               adv;
    logic signed [64:0] prod_x, prod_y;
    logic signed [32:0] ix, iy;
    logic [12:0]        cols_eff, rows_eff;
    logic signed [33:0] cols_s, rows_s;
    logic               in_bic, in_bil;
    bcgi_pkg::entry_t   e3_next;

    assign adv     = !v4_reg || q_ready;
    assign s_ready = adv;

    assign prod_x = dx1_reg * $signed({inv_x_reg[31], inv_x_reg});
    assign prod_y = dy1_reg * $signed({inv_y_reg[31], inv_y_reg});

    always_comb begin
        cols_eff = ({4'd0, grid_cols_reg} > 13'(MAX_COLS)) ? 13'(MAX_COLS)
                                                          : {4'd0, grid_cols_reg};
        rows_eff = ({4'd0, grid_rows_reg} > 13'(MAX_ROWS)) ? 13'(MAX_ROWS)
                                                          : {4'd0, grid_rows_reg};
        cols_s = $signed({21'd0, cols_eff});
        rows_s = $signed({21'd0, rows_eff});
        ix = gx2_reg[48:16];
        iy = gy2_reg[48:16];
        in_bic = (ix >= 33'sd1) && (34'(ix) < cols_s - 34'sd2)
              && (iy >= 33'sd1) && (34'(iy) < rows_s - 34'sd2);
        in_bil = (ix >= 33'sd0) && (34'(ix) < cols_s - 34'sd1)
              && (iy >= 33'sd0) && (34'(iy) < rows_s - 34'sd1);

        e3_next          = '0;
        e3_next.wr_col   = p2_reg.cell_col;
        e3_next.wr_row   = p2_reg.cell_row;
        e3_next.wr_value = p2_reg.cell_value;
        e3_next.wr_en    = ({5'd0, p2_reg.cell_col} < 13'(MAX_COLS))
                        && ({5'd0, p2_reg.cell_row} < 13'(MAX_ROWS));
        e3_next.bicubic  = in_bic;
        e3_next.col_base = in_bic ? PW'(ix - 33'sd1) : PW'(ix);
        e3_next.row_base = in_bic ? PW'(iy - 33'sd1) : PW'(iy);
        if (p2_reg.cmd == bcgi_pkg::CMD_WRITE) begin
            e3_next.kind = bcgi_pkg::K_WRITE;
        end else if (in_bic || in_bil) begin
            e3_next.kind = bcgi_pkg::K_QUERY;
        end else begin
            e3_next.kind = bcgi_pkg::K_MISS;
        end
    end

    always_comb begin
        q_valid = v4_reg;
        q_data  = e4_reg;
        if (e4_reg.bicubic) begin
            q_data.wx = bcgi_pkg::cr_weights(tx4_reg, tx2_4_reg, tx3_4_reg);
            q_data.wy = bcgi_pkg::cr_weights(ty4_reg, ty2_4_reg, ty3_4_reg);
        end else begin
            q_data.wx = {18'sd0, 18'sd0, $signed({2'd0, tx4_reg}),
                         bcgi_pkg::WGT_ONE - $signed({2'd0, tx4_reg})};
            q_data.wy = {18'sd0, 18'sd0, $signed({2'd0, ty4_reg}),
                         bcgi_pkg::WGT_ONE - $signed({2'd0, ty4_reg})};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg <= 9'd256;
            grid_rows_reg <= 9'd256;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            inv_x_reg     <= 32'sh0001_0000;
            inv_y_reg     <= 32'shFFFF_0000;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    bcgi_pkg::REG_GRID_COLS:  grid_cols_reg <= cfg_data[8:0];
                    bcgi_pkg::REG_GRID_ROWS:  grid_rows_reg <= cfg_data[8:0];
                    bcgi_pkg::REG_ORIGIN_X:   origin_x_reg  <= cfg_data;
                    bcgi_pkg::REG_ORIGIN_Y:   origin_y_reg  <= cfg_data;
                    bcgi_pkg::REG_INV_STEP_X: inv_x_reg     <= cfg_data;
                    bcgi_pkg::REG_INV_STEP_Y: inv_y_reg     <= cfg_data;
                    default: ;
                endcase
            end
            if (adv) begin
                v1_reg <= s_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
        end
        if (adv) begin
            p1_reg  <= s_data;
            dx1_reg <= $signed({s_data.world_x[31], s_data.world_x})
                     - $signed({origin_x_reg[31], origin_x_reg});
            dy1_reg <= $signed({s_data.world_y[31], s_data.world_y})
                     - $signed({origin_y_reg[31], origin_y_reg});
            p2_reg  <= p1_reg;
            gx2_reg <= prod_x[64:16];
            gy2_reg <= prod_y[64:16];
            e3_reg    <= e3_next;
            tx3_reg   <= gx2_reg[15:0];
            ty3_reg   <= gy2_reg[15:0];
            tx2_3_reg <= gx2_reg[15:0] * gx2_reg[15:0];
            ty2_3_reg <= gy2_reg[15:0] * gy2_reg[15:0];
            e4_reg    <= e3_reg;
            tx4_reg   <= tx3_reg;
            ty4_reg   <= ty3_reg;
            tx2_4_reg <= tx2_3_reg;
            ty2_4_reg <= ty2_3_reg;
            tx3_4_reg <= tx2_3_reg * tx3_reg;
            ty3_4_reg <= ty2_3_reg * ty3_reg;
        end
    end

endmodule

// File: hw/rtl/bcgi_back.sv
module bcgi_back #(
    parameter int MAX_COLS    = bcgi_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS    = bcgi_pkg::DEF_MAX_ROWS,
    parameter int SAMPLE_BITS = bcgi_pkg::DEF_SAMPLE_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  bcgi_pkg::entry_t    q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bcgi_pkg::out_item_t m_data
);

    localparam int SB        = SAMPLE_BITS;
    localparam int BANK_ROWS = (MAX_ROWS + 3) / 4;
    localparam int DEPTH     = BANK_ROWS * MAX_COLS;
    localparam int AW        = $clog2(DEPTH);
    localparam int CIW       = $clog2(MAX_COLS + 4);
    localparam int RIW       = $clog2(MAX_ROWS + 4);
    localparam int ACC_W     = SB + 20;
    localparam int RQ_W      = ACC_W - 7;
    localparam int PR_W      = RQ_W + bcgi_pkg::WGT_W;
    localparam int SUM_W     = PR_W + 3;
    localparam int V_W       = SUM_W - 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ACC,
        S_MUL,
        S_OUT
    } state_t;

    state_t                 state_reg;
    logic [1:0]             k_reg;
    logic                   rd_v_reg;
    logic [1:0]             rd_k_reg;
    bcgi_pkg::entry_t       cur_reg;
    logic signed [ACC_W-1:0] row_acc_reg [4];
    logic signed [PR_W-1:0]  prod_reg [4];
    logic                   m_valid_reg;
    bcgi_pkg::out_item_t    m_data_reg;

    logic                   out_free;
    logic                   pop;
    logic                   out_load;
    logic [3:0]             bank_we;
    logic [AW-1:0]          waddr;
    logic [SB-1:0]          wdata;
    logic [AW-1:0]          raddr [4];
    logic [SB-1:0]          rdata [4];
    logic [CIW-1:0]         rd_col;
    logic [RIW-1:0]         rd_row [4];
    logic signed [SB-1:0]   samp [4];
    logic signed [RQ_W-1:0] rowq [4];
    logic signed [ACC_W:0]  rtmp [4];
    logic signed [SUM_W-1:0] vsum;
    logic signed [V_W-1:0]  vres;

    assign out_free = !m_valid_reg || m_ready;
    assign pop = (state_reg == S_IDLE) && q_valid
              && ((q_data.kind == bcgi_pkg::K_QUERY) || out_free);
    assign out_load = (pop && (q_data.kind != bcgi_pkg::K_QUERY))
                   || ((state_reg == S_OUT) && out_free);
    assign q_ready = pop;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        waddr = AW'(({24'd0, q_data.wr_row} >> 2) * MAX_COLS + {24'd0, q_data.wr_col});
        wdata = SB'($signed(q_data.wr_value));
        for (int b = 0; b < 4; b++) begin
            bank_we[b] = pop && (q_data.kind == bcgi_pkg::K_WRITE) && q_data.wr_en
                      && (q_data.wr_row[1:0] == 2'(b));
        end
        rd_col = CIW'(cur_reg.col_base) + CIW'(k_reg);
        for (int b = 0; b < 4; b++) begin
            rd_row[b] = RIW'(cur_reg.row_base) + RIW'(2'(2'(b) - cur_reg.row_base[1:0]));
            raddr[b]  = AW'(32'(rd_row[b] >> 2) * MAX_COLS + 32'(rd_col));
        end
        for (int j = 0; j < 4; j++) begin
            // drop the neighbours that a bilinear point does not use
            if (!cur_reg.bicubic && ((j >= 2) || rd_k_reg[1])) begin
                samp[j] = '0;
            end else begin
                samp[j] = $signed(rdata[2'(cur_reg.row_base[1:0] + 2'(j))]);
            end
            rtmp[j] = $signed({row_acc_reg[j][ACC_W-1], row_acc_reg[j]}) + (ACC_W+1)'(128);
            rowq[j] = rtmp[j][ACC_W:8];
        end
        vsum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
             + SUM_W'(prod_reg[3]) + SUM_W'(32768);
        vres = vsum[SUM_W-1:16];
    end

    genvar gb;
    generate
        for (gb = 0; gb < 4; gb++) begin : g_bank
            bcgi_ram #(
                .WIDTH (SB),
                .DEPTH (DEPTH)
            ) u_ram (
                .aclk  (aclk),
                .we    (bank_we[gb]),
                .waddr (waddr),
                .wdata (wdata),
                .raddr (raddr[gb]),
                .rdata (rdata[gb])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            rd_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rd_v_reg <= (state_reg == S_READ);
            rd_k_reg <= k_reg;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (rd_v_reg) begin
                for (int j = 0; j < 4; j++) begin
                    row_acc_reg[j] <= row_acc_reg[j]
                                    + ACC_W'(samp[j] * $signed(cur_reg.wx[rd_k_reg]));
                end
            end
            case (state_reg)
                S_IDLE: begin
                    if (pop) begin
                        cur_reg <= q_data;
                        if (q_data.kind == bcgi_pkg::K_QUERY) begin
                            k_reg     <= '0;
                            state_reg <= S_READ;
                            for (int j = 0; j < 4; j++) begin
                                row_acc_reg[j] <= '0;
                            end
                        end else begin
                            // writes and off-grid points give an all-zero result
                            m_data_reg  <= '0;
                        end
                    end
                end
                S_READ: begin
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    for (int j = 0; j < 4; j++) begin
                        prod_reg[j] <= rowq[j] * $signed(cur_reg.wy[j]);
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_data_reg.value_valid  <= 1'b1;
                        m_data_reg.used_bicubic <= cur_reg.bicubic;
                        if (vres > V_W'(24'sh7F_FFFF)) begin
                            m_data_reg.value     <= 24'sh7F_FFFF;
                            m_data_reg.saturated <= 1'b1;
                        end else if (vres < V_W'(24'sh80_0000)) begin
                            m_data_reg.value     <= 24'sh80_0000;
                            m_data_reg.saturated <= 1'b1;
                        end else begin
                            m_data_reg.value     <= vres[23:0];
                            m_data_reg.saturated <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
